// ----- rtl/image_sample_unpack_decode_defines.svh -----
// Assertion helpers for the top-level file, which checks its own logic.
`ifndef IMAGE_SAMPLE_UNPACK_DECODE_DEFINES_SVH
`define IMAGE_SAMPLE_UNPACK_DECODE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ISUD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ISUD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/isud_pkg.sv -----
`timescale 1ns / 1ps
package isud_pkg;

   localparam int COMP_W      = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int DIV_STEPS   = 16;
   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_DATA_W  = 64;

   localparam logic [15:0] SCALE_NARROW = 16'h00ff;
   localparam logic [15:0] SCALE_WIDE   = 16'hffff;

   localparam logic [2:0] REG_BITS_CODE      = 3'd0;
   localparam logic [2:0] REG_NUM_COMPONENTS = 3'd1;
   localparam logic [2:0] REG_OUTPUT_WIDE    = 3'd2;
   localparam logic [2:0] REG_ROW_SAMPLES    = 3'd3;
   localparam logic [2:0] REG_PAIR_0         = 3'd4;
   localparam logic [2:0] REG_PAIR_1         = 3'd5;
   localparam logic [2:0] REG_PAIR_2         = 3'd6;
   localparam logic [2:0] REG_PAIR_3         = 3'd7;

   localparam logic [2:0]  RST_BITS_CODE      = 3'd3;
   localparam logic [2:0]  RST_NUM_COMPONENTS = 3'd1;
   localparam logic [15:0] RST_ROW_SAMPLES    = 16'd1;
   localparam logic [63:0] RST_PAIR           = 64'h0001_0000_0000_0000;

   typedef struct packed {
      logic [2:0]  bits_code;
      logic [2:0]  num_components;
      logic        output_wide;
      logic [15:0] row_samples;
   } cfg_type;

   typedef struct packed {
      logic [15:0]       value;
      logic [COMP_W-1:0] comp;
      logic              last;
      logic              row_end;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_SUM,
      BK_CLASS,
      BK_DIV,
      BK_DONE
   } bk_state_type;

endpackage

// ----- rtl/isud_front.sv -----
`timescale 1ns / 1ps
module isud_front #(
   parameter int MAX_COMPONENTS = 4,
   parameter int ROW_COUNT_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  isud_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   output logic              push,
   output isud_pkg::job_type push_job,
   input  logic              q_full
);
   import isud_pkg::*;

   localparam int CMP_W = (ROW_COUNT_BITS > 16) ? ROW_COUNT_BITS : 16;

   logic                      busy_ff, busy_in;
   logic [7:0]                byte_ff, byte_in;
   logic [2:0]                bitpos_ff, bitpos_in;
   logic [COMP_W-1:0]         comp_pos_ff, comp_pos_in;
   logic [ROW_COUNT_BITS-1:0] row_count_ff, row_count_in;
   logic [7:0]                held_ff, held_in;
   logic                      hbv_ff, hbv_in;

   logic                      wide;
   logic                      accept;
   logic [2:0]                nc;
   logic [COMP_W-1:0]         comp_cur;
   logic [2:0]                comp_inc;
   logic [ROW_COUNT_BITS-1:0] next_row;
   logic                      row_done;
   logic [7:0]                shifted;
   logic [15:0]               narrow_value;
   logic [3:0]                step;
   logic [3:0]                bit_sum;
   logic                      last;

   assign wide      = cfg.bits_code[2];
   assign req_ready = !busy_ff;
   assign accept    = req_valid && !busy_ff;

   always_comb begin
      if (cfg.num_components == 3'd0) begin
         nc = 3'd1;
      end else if (cfg.num_components > 3'(MAX_COMPONENTS)) begin
         nc = 3'(MAX_COMPONENTS);
      end else begin
         nc = cfg.num_components;
      end
   end

   // A stale component position from an earlier, larger count restarts at zero.
   assign comp_cur = ({1'b0, comp_pos_ff} >= nc) ? '0 : comp_pos_ff;
   assign comp_inc = {1'b0, comp_cur} + 3'd1;

   assign next_row = row_count_ff + {{(ROW_COUNT_BITS-1){1'b0}}, 1'b1};
   assign row_done = (CMP_W'(next_row) == CMP_W'(cfg.row_samples));

   assign shifted = byte_ff << bitpos_ff;

   always_comb begin
      unique case (cfg.bits_code[1:0])
         2'd0: begin
            narrow_value = {15'd0, shifted[7]};
            step         = 4'd1;
         end
         2'd1: begin
            narrow_value = {14'd0, shifted[7:6]};
            step         = 4'd2;
         end
         2'd2: begin
            narrow_value = {12'd0, shifted[7:4]};
            step         = 4'd4;
         end
         2'd3: begin
            narrow_value = {8'd0, shifted};
            step         = 4'd8;
         end
         default: begin
            narrow_value = '0;
            step         = 4'd8;
         end
      endcase
   end

   assign bit_sum = {1'b0, bitpos_ff} + step;
   assign last    = wide || row_done || bit_sum[3];

   always_comb begin
      busy_in      = busy_ff;
      byte_in      = byte_ff;
      bitpos_in    = bitpos_ff;
      comp_pos_in  = comp_pos_ff;
      row_count_in = row_count_ff;
      held_in      = held_ff;
      hbv_in       = hbv_ff;
      push         = 1'b0;
      push_job     = '0;

      if (accept) begin
         if (wide && !hbv_ff) begin
            // High byte of a 16-bit sample waits for its partner.
            held_in = req_data_byte;
            hbv_in  = 1'b1;
         end else begin
            byte_in   = req_data_byte;
            busy_in   = 1'b1;
            bitpos_in = '0;
            hbv_in    = 1'b0;
         end
      end

      if (busy_ff && !q_full) begin
         push             = 1'b1;
         push_job.value   = wide ? {held_ff, byte_ff} : narrow_value;
         push_job.comp    = comp_cur;
         push_job.last    = last;
         push_job.row_end = row_done;
         row_count_in     = row_done ? '0 : next_row;
         comp_pos_in      = (comp_inc >= nc) ? '0 : comp_inc[COMP_W-1:0];
         if (last) begin
            busy_in   = 1'b0;
            bitpos_in = '0;
         end else begin
            bitpos_in = bit_sum[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         bitpos_ff    <= '0;
         comp_pos_ff  <= '0;
         row_count_ff <= '0;
         hbv_ff       <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         bitpos_ff    <= bitpos_in;
         comp_pos_ff  <= comp_pos_in;
         row_count_ff <= row_count_in;
         hbv_ff       <= hbv_in;
      end
      byte_ff <= byte_in;
      held_ff <= held_in;
   end

endmodule

// ----- rtl/isud_queue.sv -----
`timescale 1ns / 1ps
module isud_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  isud_pkg::job_type push_job,
   input  logic              pop,
   output isud_pkg::job_type head,
   output logic              full,
   output logic              empty
);
   import isud_pkg::*;

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/isud_back.sv -----
`timescale 1ns / 1ps
module isud_back (
   input  logic                        clock,
   input  logic                        reset,
   input  isud_pkg::cfg_type           cfg,
   input  logic                        q_empty,
   input  isud_pkg::job_type           q_head,
   output logic                        q_pop,
   output logic [isud_pkg::COMP_W-1:0] comp_sel,
   input  logic [31:0]                 dmin,
   input  logic [31:0]                 dmax,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [15:0]                 rsp_sample_value,
   output logic [1:0]                  rsp_component_index,
   output logic                        rsp_last_of_byte,
   output logic                        rsp_row_end
);
   import isud_pkg::*;

   bk_state_type        state_ff, state_in;
   job_type             job_ff, job_in;
   logic signed [48:0]  base_ff, base_in;
   logic signed [49:0]  prod_ff, prod_in;
   logic [50:0]         num_ff, num_in;
   logic [32:0]         rem_ff, rem_in;
   logic [15:0]         quo_ff, quo_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic                out_valid_ff, out_valid_in;
   logic [15:0]         out_value_ff, out_value_in;
   logic [1:0]          out_comp_ff, out_comp_in;
   logic                out_last_ff, out_last_in;
   logic                out_end_ff, out_end_in;

   logic do_mul, do_sum, do_cls, do_div, do_out;
   logic out_free;

   logic [4:0]         width;
   logic [16:0]        maxcode17;
   logic [31:0]        den;
   logic signed [48:0] dmin_x;
   logic signed [32:0] diff;
   logic signed [16:0] v_s;
   logic               positive;
   logic               saturate;
   logic [31:0]        n32;
   logic [47:0]        scaled;
   logic [15:0]        scale;
   logic [32:0]        trial;
   logic               qbit;
   logic               div_last;

   assign comp_sel = job_ff.comp;
   assign out_free = !out_valid_ff || rsp_ready;
   assign div_last = (cnt_ff == 4'(DIV_STEPS - 1));

   always_comb begin
      if (cfg.bits_code[2]) begin
         width = 5'd16;
      end else begin
         unique case (cfg.bits_code[1:0])
            2'd0:    width = 5'd1;
            2'd1:    width = 5'd2;
            2'd2:    width = 5'd4;
            2'd3:    width = 5'd8;
            default: width = 5'd8;
         endcase
      end
   end

   assign maxcode17 = (17'd1 << width) - 17'd1;
   assign den       = {maxcode17[15:0], 16'h0000};
   assign scale     = cfg.output_wide ? SCALE_WIDE : SCALE_NARROW;

   // dmin * maxcode is a shift and a subtract, since maxcode is 2^w - 1.
   assign dmin_x = {{17{dmin[31]}}, dmin};
   assign diff   = $signed({dmax[31], dmax}) - $signed({dmin[31], dmin});
   assign v_s    = $signed({1'b0, job_ff.value});

   assign positive = !num_ff[50] && (num_ff != '0);
   assign saturate = (|num_ff[49:32]) || (num_ff[31:0] >= den);
   assign n32      = num_ff[31:0];
   assign scaled   = cfg.output_wide ? ({n32, 16'h0000} - {16'h0000, n32})
                                     : ({8'h00, n32, 8'h00} - {16'h0000, n32});

   assign trial = {rem_ff[31:0], quo_ff[15]};
   assign qbit  = (trial >= {1'b0, den});

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (!q_empty) state_in = BK_MUL;
         BK_MUL:   state_in = BK_SUM;
         BK_SUM:   state_in = BK_CLASS;
         BK_CLASS: state_in = (positive && !saturate) ? BK_DIV : BK_DONE;
         BK_DIV:   if (div_last) state_in = BK_DONE;
         BK_DONE:  if (out_free) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // Control outputs of each state.
   always_comb begin
      q_pop  = 1'b0;
      do_mul = 1'b0;
      do_sum = 1'b0;
      do_cls = 1'b0;
      do_div = 1'b0;
      do_out = 1'b0;
      unique case (state_ff)
         BK_IDLE:  q_pop  = !q_empty;
         BK_MUL:   do_mul = 1'b1;
         BK_SUM:   do_sum = 1'b1;
         BK_CLASS: do_cls = 1'b1;
         BK_DIV:   do_div = 1'b1;
         BK_DONE:  do_out = out_free;
         default:  q_pop  = 1'b0;
      endcase
   end

   always_comb begin
      job_in       = job_ff;
      base_in      = base_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_comp_in  = out_comp_ff;
      out_last_in  = out_last_ff;
      out_end_in   = out_end_ff;

      if (q_pop) begin
         job_in = q_head;
      end
      if (do_mul) begin
         base_in = (dmin_x <<< width) - dmin_x;
         prod_in = v_s * diff;
      end
      if (do_sum) begin
         num_in = {{2{base_ff[48]}}, base_ff} + {prod_ff[49], prod_ff};
      end
      if (do_cls) begin
         // The upper part of the scaled numerator is already below den.
         rem_in = {1'b0, scaled[47:16]};
         cnt_in = '0;
         if (!positive) begin
            quo_in = '0;
         end else if (saturate) begin
            quo_in = scale;
         end else begin
            quo_in = scaled[15:0];
         end
      end
      if (do_div) begin
         rem_in = qbit ? (trial - {1'b0, den}) : trial;
         quo_in = {quo_ff[14:0], qbit};
         cnt_in = cnt_ff + 4'd1;
      end

      if (do_out) begin
         out_valid_in = 1'b1;
         out_value_in = quo_ff;
         out_comp_in  = job_ff.comp;
         out_last_in  = job_ff.last;
         out_end_in   = job_ff.row_end;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff       <= job_in;
      base_ff      <= base_in;
      prod_ff      <= prod_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      out_value_ff <= out_value_in;
      out_comp_ff  <= out_comp_in;
      out_last_ff  <= out_last_in;
      out_end_ff   <= out_end_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_sample_value    = out_value_ff;
   assign rsp_component_index = out_comp_ff;
   assign rsp_last_of_byte    = out_last_ff;
   assign rsp_row_end         = out_end_ff;

endmodule

// ----- rtl/image_sample_unpack_decode.sv -----
`timescale 1ns / 1ps
// Channel   | Direction | Handshake               | Payload
// req       | in        | req_valid / req_ready   | req_data_byte
// rsp       | out       | rsp_valid / rsp_ready   | sample_value, component_index,
//           |           |                         | last_of_byte, row_end
// csr       | in/out    | psel, penable, pwrite   | paddr (8 * register), 64-bit data
//
// The unpacker takes a byte and then queues one sample per cycle while the
// queue is not full. Each sample passes the decoder's multiply, sum and
// classify steps and, unless clamped to 0 or full scale, the 16-step restoring
// divider, one quotient bit a cycle. Synchronous reset loads register defaults
// and empties the queue. A stalled result register holds its item while the
// four-entry queue keeps the unpacker busy.
`include "image_sample_unpack_decode_defines.svh"
module image_sample_unpack_decode #(
   parameter int MAX_COMPONENTS = 4,
   parameter int ROW_COUNT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [15:0]                     rsp_sample_value,
   output logic [1:0]                      rsp_component_index,
   output logic                            rsp_last_of_byte,
   output logic                            rsp_row_end,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [isud_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [isud_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [isud_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import isud_pkg::*;

   logic [2:0]  bits_code_ff, bits_code_in;
   logic [2:0]  num_comp_ff, num_comp_in;
   logic        output_wide_ff, output_wide_in;
   logic [15:0] row_samples_ff, row_samples_in;
   logic [63:0] pair_ff [MAX_COMPONENTS];
   logic [63:0] pair_in [MAX_COMPONENTS];

   cfg_type           cfg;
   logic              csr_write;
   logic [2:0]        csr_index;
   logic [1:0]        pair_index;
   logic [63:0]       pair_rd;
   logic [COMP_W-1:0] comp_sel;
   logic [63:0]       pair_sel;
   logic              rsp_comp_ok;

   logic    q_push, q_pop, q_full, q_empty;
   job_type push_job, q_head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[5:3];
   assign pair_index = 2'(csr_index - REG_PAIR_0);

   assign cfg.bits_code      = bits_code_ff;
   assign cfg.num_components = num_comp_ff;
   assign cfg.output_wide    = output_wide_ff;
   assign cfg.row_samples    = row_samples_ff;

   always_comb begin
      bits_code_in   = bits_code_ff;
      num_comp_in    = num_comp_ff;
      output_wide_in = output_wide_ff;
      row_samples_in = row_samples_ff;
      for (int i = 0; i < MAX_COMPONENTS; i++) begin
         pair_in[i] = pair_ff[i];
      end
      if (csr_write) begin
         unique case (csr_index)
            REG_BITS_CODE:      bits_code_in   = csr_pwdata[2:0];
            REG_NUM_COMPONENTS: num_comp_in    = csr_pwdata[2:0];
            REG_OUTPUT_WIDE:    output_wide_in = csr_pwdata[0];
            REG_ROW_SAMPLES:    row_samples_in = csr_pwdata[15:0];
            REG_PAIR_0, REG_PAIR_1, REG_PAIR_2, REG_PAIR_3: begin
               // Pairs beyond the component limit are never used and not kept.
               for (int i = 0; i < MAX_COMPONENTS; i++) begin
                  if (pair_index == 2'(i)) begin
                     pair_in[i] = csr_pwdata;
                  end
               end
            end
            default: bits_code_in = bits_code_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_code_ff   <= RST_BITS_CODE;
         num_comp_ff    <= RST_NUM_COMPONENTS;
         output_wide_ff <= 1'b0;
         row_samples_ff <= RST_ROW_SAMPLES;
         for (int i = 0; i < MAX_COMPONENTS; i++) begin
            pair_ff[i] <= RST_PAIR;
         end
      end else begin
         bits_code_ff   <= bits_code_in;
         num_comp_ff    <= num_comp_in;
         output_wide_ff <= output_wide_in;
         row_samples_ff <= row_samples_in;
         for (int i = 0; i < MAX_COMPONENTS; i++) begin
            pair_ff[i] <= pair_in[i];
         end
      end
   end

   always_comb begin
      pair_rd = '0;
      for (int i = 0; i < MAX_COMPONENTS; i++) begin
         if (pair_index == 2'(i)) begin
            pair_rd = pair_ff[i];
         end
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_BITS_CODE:      csr_prdata = {61'd0, bits_code_ff};
         REG_NUM_COMPONENTS: csr_prdata = {61'd0, num_comp_ff};
         REG_OUTPUT_WIDE:    csr_prdata = {63'd0, output_wide_ff};
         REG_ROW_SAMPLES:    csr_prdata = {48'd0, row_samples_ff};
         REG_PAIR_0, REG_PAIR_1, REG_PAIR_2, REG_PAIR_3: csr_prdata = pair_rd;
         default:            csr_prdata = '0;
      endcase
   end

   always_comb begin
      pair_sel = RST_PAIR;
      for (int i = 0; i < MAX_COMPONENTS; i++) begin
         if (comp_sel == COMP_W'(i)) begin
            pair_sel = pair_ff[i];
         end
      end
   end

   isud_front #(
      .MAX_COMPONENTS (MAX_COMPONENTS),
      .ROW_COUNT_BITS (ROW_COUNT_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .push          (q_push),
      .push_job      (push_job),
      .q_full        (q_full)
   );

   isud_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head     (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   isud_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .q_empty             (q_empty),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .comp_sel            (comp_sel),
      .dmin                (pair_sel[31:0]),
      .dmax                (pair_sel[63:32]),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sample_value    (rsp_sample_value),
      .rsp_component_index (rsp_component_index),
      .rsp_last_of_byte    (rsp_last_of_byte),
      .rsp_row_end         (rsp_row_end)
   );

   assign rsp_comp_ok = ({1'b0, rsp_component_index} < 3'(MAX_COMPONENTS));

   `ISUD_ASSERT_NOW(a_push_has_space, q_push, !q_full, "sample pushed into a full queue")
   `ISUD_ASSERT_NOW(a_pop_has_entry, q_pop, !q_empty, "sample popped from an empty queue")
   `ISUD_ASSERT_NEXT(a_push_fills, q_push, !q_empty, "queue empty right after a push")
   `ISUD_ASSERT_NOW(a_comp_range, rsp_valid, rsp_comp_ok, "component index beyond the limit")

endmodule
